// ===== src/monotone_cubic_tangent_engine_unit_macros.svh =====
// Assertion macros shared by the tangent engine.
`ifndef MONOTONE_CUBIC_TANGENT_ENGINE_UNIT_MACROS_SVH
`define MONOTONE_CUBIC_TANGENT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCTU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mctu_pkg.sv =====
package mctu_pkg;

   // Fixed field geometry.
   localparam int CW     = 32;
   localparam int AXES   = 6;
   localparam int AX_W   = 3;
   localparam int DW     = CW + 1;
   localparam int MW     = CW + 4;
   localparam int PW     = 2 * MW;
   localparam int SQW    = 2 * CW;
   localparam int RW     = CW;
   localparam int DVW    = 2 * CW + 2;
   localparam int MDIG   = 8;
   localparam int MSTEPS = (MW + MDIG - 1) / MDIG;
   localparam int BPW    = MSTEPS * MDIG;
   localparam int MSW    = 3;
   localparam int DSW    = 7;
   localparam int SSW    = 5;

   typedef logic signed [CW-1:0] coord_type;
   typedef coord_type [AXES-1:0] row_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_AX_RD0, ST_AX_RD1, ST_AX_RD2, ST_SEG_RD, ST_SEG_M1, ST_EVAL,
      ST_MUL_AX, ST_MUL_YY, ST_CMP, ST_MUL_M0SQ, ST_MUL_M1SQ, ST_SQRT,
      ST_MUL_M0D, ST_DIV_M0, ST_MUL_M1D, ST_DIV_M1, ST_SEG_WR, ST_LAST_WR, ST_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_RD0, OP_RD1, OP_RD2, OP_SEGRD, OP_SEGM1, OP_EVAL,
      OP_SEGWR, OP_LASTWR, OP_OUT
   } dp_op_type;

   typedef enum logic [2:0] {
      MS_AX, MS_YY, MS_M0SQ, MS_M1SQ, MS_M0D, MS_M1D
   } mul_sel_type;

   typedef enum logic {
      DS_M0, DS_M1
   } div_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        mul_run;
      mul_sel_type mul_sel;
      logic        div_run;
      div_sel_type div_sel;
      logic        sqrt_run;
   } dp_cmd_type;

   typedef struct packed {
      logic single;
      logic seg_more;
      logic flat;
      logic region;
      logic a_pos;
      logic lt;
      logic axis_last;
      logic out_last;
      logic mul_done;
      logic div_done;
      logic sqrt_done;
   } dp_stat_type;

endpackage

// ===== src/mctu_mul.sv =====
module mctu_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         run,
   input  logic [mctu_pkg::MW-1:0]      op_a,
   input  logic [mctu_pkg::MW-1:0]      op_b,
   output logic                         done,
   output logic [mctu_pkg::PW-1:0]      res
);

   logic                                busy_ff, busy_in;
   logic [mctu_pkg::MSW-1:0]            step_ff, step_in;
   logic [mctu_pkg::MW-1:0]             a_ff, a_in;
   logic [mctu_pkg::BPW-1:0]            b_ff, b_in;
   logic [mctu_pkg::PW-1:0]             acc_ff, acc_in;
   logic [mctu_pkg::MW+mctu_pkg::MDIG-1:0] part;
   logic [mctu_pkg::PW-1:0]             acc_next;

   // One byte of the multiplier per cycle, most significant first.
   always_comb begin
      part     = a_ff * b_ff[mctu_pkg::BPW-1 -: mctu_pkg::MDIG];
      acc_next = (acc_ff << mctu_pkg::MDIG) + mctu_pkg::PW'(part);
      done     = busy_ff && (step_ff == mctu_pkg::MSW'(mctu_pkg::MSTEPS - 1));
      res      = acc_next;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (!busy_ff && run) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = op_a;
         b_in    = mctu_pkg::BPW'(op_b);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_next;
         b_in    = b_ff << mctu_pkg::MDIG;
         step_in = step_ff + mctu_pkg::MSW'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== src/mctu_div.sv =====
module mctu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      run,
   input  logic [mctu_pkg::DVW-1:0]  num,
   input  logic [mctu_pkg::RW-1:0]   den,
   output logic                      done,
   output logic [mctu_pkg::DVW-1:0]  quo
);

   logic                         busy_ff, busy_in;
   logic [mctu_pkg::DSW-1:0]     step_ff, step_in;
   logic [mctu_pkg::RW:0]        rem_ff, rem_in;
   logic [mctu_pkg::DVW-1:0]     nq_ff, nq_in;
   logic [mctu_pkg::RW-1:0]      den_ff, den_in;
   logic [mctu_pkg::RW+1:0]      shifted, trial;
   logic                         ge;
   logic [mctu_pkg::DVW-1:0]     q_next;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      shifted = {rem_ff, nq_ff[mctu_pkg::DVW-1]};
      trial   = shifted - (mctu_pkg::RW + 2)'(den_ff);
      ge      = !trial[mctu_pkg::RW+1];
      q_next  = {nq_ff[mctu_pkg::DVW-2:0], ge};
      done    = busy_ff && (step_ff == mctu_pkg::DSW'(mctu_pkg::DVW - 1));
      quo     = q_next;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      den_in  = den_ff;
      if (!busy_ff && run) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         nq_in   = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[mctu_pkg::RW:0] : shifted[mctu_pkg::RW:0];
         nq_in   = q_next;
         step_in = step_ff + mctu_pkg::DSW'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
   end

endmodule

// ===== src/mctu_root.sv =====
module mctu_root (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      run,
   input  logic [mctu_pkg::SQW-1:0]  rad,
   output logic                      done,
   output logic [mctu_pkg::RW-1:0]   root
);

   logic                         busy_ff, busy_in;
   logic [mctu_pkg::SSW-1:0]     step_ff, step_in;
   logic [mctu_pkg::SQW-1:0]     x_ff, x_in;
   logic [mctu_pkg::RW+1:0]      rem_ff, rem_in;
   logic [mctu_pkg::RW-1:0]      q_ff, q_in;
   logic [mctu_pkg::RW+3:0]      shifted, trial;
   logic                         ge;
   logic [mctu_pkg::RW-1:0]      q_next;

   // Digit-by-digit square root, one root bit per cycle.
   always_comb begin
      shifted = {rem_ff, x_ff[mctu_pkg::SQW-1 -: 2]};
      trial   = shifted - (mctu_pkg::RW + 4)'({q_ff, 2'b01});
      ge      = !trial[mctu_pkg::RW+3];
      q_next  = {q_ff[mctu_pkg::RW-2:0], ge};
      done    = busy_ff && (step_ff == mctu_pkg::SSW'(mctu_pkg::RW - 1));
      root    = q_next;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (!busy_ff && run) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = rad;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[mctu_pkg::RW+1:0] : shifted[mctu_pkg::RW+1:0];
         q_in    = q_next;
         x_in    = x_ff << 2;
         step_in = step_ff + mctu_pkg::SSW'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

endmodule

// ===== src/mctu_dp.sv =====
module mctu_dp #(
   parameter int MAX_POINTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mctu_pkg::dp_cmd_type  cmd,
   input  mctu_pkg::row_type     load_row,
   output mctu_pkg::dp_stat_type stat,
   output mctu_pkg::row_type     out_row,
   output logic                  out_valid,
   output logic                  out_last,
   output logic                  out_drop
);

   localparam int IDXW = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);

   // Control registers.
   logic [CNTW-1:0]               cnt_ff, cnt_in;
   logic                          drop_ff, drop_in;
   logic [IDXW-1:0]               idx_ff, idx_in;
   logic [mctu_pkg::AX_W-1:0]     axis_ff, axis_in;
   logic                          out_valid_ff, out_valid_in;

   // Payload registers.
   mctu_pkg::coord_type           pi_ff, pi_in, pj_ff, pj_in, m0_ff, m0_in, m1_ff, m1_in;
   logic [mctu_pkg::PW-1:0]       lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [mctu_pkg::SQW-1:0]      sq0_ff, sq0_in, sq1_ff, sq1_in, num_ff, num_in;
   logic [mctu_pkg::RW-1:0]       s_ff, s_in;
   logic                          out_last_ff, out_last_in, out_drop_ff, out_drop_in;

   // Point and tangent stores.
   mctu_pkg::row_type             pt_mem_ff [MAX_POINTS];
   mctu_pkg::row_type             tan_mem_ff [MAX_POINTS];
   mctu_pkg::row_type             pt_rd_ff, tan_rd_ff;
   logic                          pt_wr, pt_rd, tan_wr, tan_rd;
   logic [IDXW-1:0]               pt_addr;

   // Segment arithmetic.
   logic [CNTW:0]                 idx1, idx2, n_ext;
   logic                          full;
   mctu_pkg::coord_type           col, half;
   logic signed [mctu_pkg::DW-1:0] d, e, e_adj;
   logic                          dneg;
   logic [mctu_pkg::DW-1:0]       dm;
   logic signed [mctu_pkg::MW-1:0] m0x, m1x, a, b, dmx, x, y, z, a3;
   logic [mctu_pkg::MW-1:0]       m0mag, m1mag;

   // Iterative unit hookup.
   logic [mctu_pkg::MW-1:0]       mul_a, mul_b;
   logic                          mul_done, div_done, root_done;
   logic [mctu_pkg::PW-1:0]       mul_res;
   logic [mctu_pkg::DVW-1:0]      div_num, div_quo;
   logic [mctu_pkg::RW-1:0]       root_res;

   // Scales a quotient back to a tangent and clips it to the coordinate range.
   function automatic mctu_pkg::coord_type rescale_sat(
      input logic [mctu_pkg::DVW-1:0] q,
      input logic                     neg
   );
      logic                ovf;
      mctu_pkg::coord_type val;
      if (!neg) begin
         ovf = |q[mctu_pkg::DVW-1:mctu_pkg::CW-1];
         val = ovf ? {1'b0, {(mctu_pkg::CW - 1){1'b1}}} : q[mctu_pkg::CW-1:0];
      end else begin
         ovf = (|q[mctu_pkg::DVW-1:mctu_pkg::CW]) ||
               (q[mctu_pkg::CW-1] && (|q[mctu_pkg::CW-2:0]));
         val = ovf ? {1'b1, {(mctu_pkg::CW - 1){1'b0}}} : -q[mctu_pkg::CW-1:0];
      end
      return val;
   endfunction

   // Index bookkeeping.
   always_comb begin
      n_ext = (CNTW + 1)'(cnt_ff);
      idx1  = (CNTW + 1)'(idx_ff) + (CNTW + 1)'(1);
      idx2  = (CNTW + 1)'(idx_ff) + (CNTW + 1)'(2);
      full  = (cnt_ff == CNTW'(MAX_POINTS));
   end

   // Segment slope, region test terms and magnitudes.
   always_comb begin
      col   = pt_rd_ff[axis_ff];
      d     = {pj_ff[mctu_pkg::CW-1], pj_ff} - {pi_ff[mctu_pkg::CW-1], pi_ff};
      dneg  = d[mctu_pkg::DW-1];
      dm    = dneg ? -d : d;
      e     = {col[mctu_pkg::CW-1], col} - {pi_ff[mctu_pkg::CW-1], pi_ff};
      e_adj = e + mctu_pkg::DW'(e[mctu_pkg::DW-1]);
      half  = mctu_pkg::CW'(e_adj >>> 1);
      m0x   = mctu_pkg::MW'(m0_ff);
      m1x   = mctu_pkg::MW'(m1_ff);
      a     = dneg ? -m0x : m0x;
      b     = dneg ? -m1x : m1x;
      dmx   = mctu_pkg::MW'(dm);
      x     = a + b - (dmx <<< 1);
      y     = (a <<< 1) + b - (dmx <<< 1) - dmx;
      z     = a + (b <<< 1) - (dmx <<< 1) - dmx;
      a3    = (a <<< 1) + a;
      m0mag = m0_ff[mctu_pkg::CW-1] ? -m0x : m0x;
      m1mag = m1_ff[mctu_pkg::CW-1] ? -m1x : m1x;
   end

   // Operand selection for the shared units.
   always_comb begin
      case (cmd.mul_sel)
         mctu_pkg::MS_AX: begin
            mul_a = a3;
            mul_b = x;
         end
         mctu_pkg::MS_YY: begin
            mul_a = y;
            mul_b = y;
         end
         mctu_pkg::MS_M0SQ: begin
            mul_a = m0mag;
            mul_b = m0mag;
         end
         mctu_pkg::MS_M1SQ: begin
            mul_a = m1mag;
            mul_b = m1mag;
         end
         mctu_pkg::MS_M0D: begin
            mul_a = m0mag;
            mul_b = dmx;
         end
         mctu_pkg::MS_M1D: begin
            mul_a = m1mag;
            mul_b = dmx;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      div_num = (mctu_pkg::DVW'(num_ff) << 1) + mctu_pkg::DVW'(num_ff);
   end

   mctu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .run   (cmd.mul_run),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .res   (mul_res)
   );

   mctu_div u_div (
      .clock (clock),
      .reset (reset),
      .run   (cmd.div_run),
      .num   (div_num),
      .den   (s_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   mctu_root u_root (
      .clock (clock),
      .reset (reset),
      .run   (cmd.sqrt_run),
      .rad   (sq0_ff + sq1_ff),
      .done  (root_done),
      .root  (root_res)
   );

   // Status back to the controller.
   always_comb begin
      stat.single    = (cnt_ff == CNTW'(1));
      stat.seg_more  = (idx2 < n_ext);
      stat.flat      = (d == '0);
      stat.region    = (x > 0) && (y > 0) && (z > 0);
      stat.a_pos     = (a > 0);
      stat.lt        = (lhs_ff < rhs_ff);
      stat.axis_last = (axis_ff == mctu_pkg::AX_W'(mctu_pkg::AXES - 1));
      stat.out_last  = (idx1 == n_ext);
      stat.mul_done  = mul_done;
      stat.div_done  = div_done;
      stat.sqrt_done = root_done;
   end

   // Register updates per command.
   always_comb begin
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      axis_in      = axis_ff;
      out_valid_in = 1'b0;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      m0_in        = m0_ff;
      m1_in        = m1_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      sq0_in       = sq0_ff;
      sq1_in       = sq1_ff;
      num_in       = num_ff;
      s_in         = s_ff;
      pt_wr        = 1'b0;
      pt_rd        = 1'b0;
      pt_addr      = '0;
      tan_wr       = 1'b0;
      tan_rd       = 1'b0;
      case (cmd.op)
         mctu_pkg::OP_LOAD: begin
            if (!full) begin
               pt_wr  = 1'b1;
               cnt_in = cnt_ff + CNTW'(1);
            end else begin
               drop_in = 1'b1;
            end
         end
         mctu_pkg::OP_RD0: begin
            pt_rd  = 1'b1;
            idx_in = '0;
            m0_in  = '0;
         end
         mctu_pkg::OP_RD1: begin
            pi_in   = col;
            pt_rd   = 1'b1;
            pt_addr = IDXW'(1);
         end
         mctu_pkg::OP_RD2: begin
            pj_in = col;
         end
         mctu_pkg::OP_SEGRD: begin
            pt_rd   = stat.seg_more;
            pt_addr = idx2[IDXW-1:0];
         end
         mctu_pkg::OP_SEGM1: begin
            m1_in = stat.seg_more ? half : '0;
         end
         mctu_pkg::OP_EVAL: begin
            if (stat.flat) begin
               m0_in = '0;
               m1_in = '0;
            end
         end
         mctu_pkg::OP_SEGWR: begin
            tan_wr = 1'b1;
            m0_in  = m1_ff;
            pi_in  = pj_ff;
            pj_in  = col;
            idx_in = idx1[IDXW-1:0];
         end
         mctu_pkg::OP_LASTWR: begin
            tan_wr  = 1'b1;
            idx_in  = '0;
            axis_in = stat.axis_last ? '0 : axis_ff + mctu_pkg::AX_W'(1);
         end
         mctu_pkg::OP_OUT: begin
            tan_rd       = 1'b1;
            out_valid_in = 1'b1;
            out_last_in  = stat.out_last;
            out_drop_in  = drop_ff;
            idx_in       = idx1[IDXW-1:0];
            if (stat.out_last) begin
               cnt_in  = '0;
               drop_in = 1'b0;
               idx_in  = '0;
            end
         end
         default: begin
         end
      endcase

      // Results of the iterative units.
      if (mul_done) begin
         case (cmd.mul_sel)
            mctu_pkg::MS_AX:   lhs_in = mul_res;
            mctu_pkg::MS_YY:   rhs_in = mul_res;
            mctu_pkg::MS_M0SQ: sq0_in = mul_res[mctu_pkg::SQW-1:0];
            mctu_pkg::MS_M1SQ: sq1_in = mul_res[mctu_pkg::SQW-1:0];
            default:           num_in = mul_res[mctu_pkg::SQW-1:0];
         endcase
      end
      if (root_done) begin
         s_in = root_res;
      end
      if (div_done) begin
         if (cmd.div_sel == mctu_pkg::DS_M0) begin
            m0_in = rescale_sat(div_quo, m0_ff[mctu_pkg::CW-1]);
         end else begin
            m1_in = rescale_sat(div_quo, m1_ff[mctu_pkg::CW-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         axis_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         idx_ff       <= idx_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff       <= pi_in;
      pj_ff       <= pj_in;
      m0_ff       <= m0_in;
      m1_ff       <= m1_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      sq0_ff      <= sq0_in;
      sq1_ff      <= sq1_in;
      num_ff      <= num_in;
      s_ff        <= s_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   // Point store: one row written per load, one row read per fetch.
   always_ff @(posedge clock) begin
      if (pt_wr) begin
         pt_mem_ff[cnt_ff[IDXW-1:0]] <= load_row;
      end
      if (pt_rd) begin
         pt_rd_ff <= pt_mem_ff[pt_addr];
      end
   end

   // Tangent store: one axis word written, a whole row read for output.
   always_ff @(posedge clock) begin
      if (tan_wr) begin
         tan_mem_ff[idx_ff][axis_ff] <= m0_ff;
      end
      if (tan_rd) begin
         tan_rd_ff <= tan_mem_ff[idx_ff];
      end
   end

   assign out_row   = tan_rd_ff;
   assign out_valid = out_valid_ff;
   assign out_last  = out_last_ff;
   assign out_drop  = out_drop_ff;

endmodule

// ===== src/mctu_ctrl.sv =====
module mctu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  last_point,
   input  mctu_pkg::dp_stat_type stat,
   output mctu_pkg::dp_cmd_type  cmd,
   output logic                  busy
);

   mctu_pkg::ctrl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mctu_pkg::ST_IDLE: begin
            if (start && last_point) begin
               state_in = mctu_pkg::ST_AX_RD0;
            end
         end
         mctu_pkg::ST_AX_RD0: state_in = mctu_pkg::ST_AX_RD1;
         mctu_pkg::ST_AX_RD1: begin
            state_in = stat.single ? mctu_pkg::ST_LAST_WR : mctu_pkg::ST_AX_RD2;
         end
         mctu_pkg::ST_AX_RD2: state_in = mctu_pkg::ST_SEG_RD;
         mctu_pkg::ST_SEG_RD: state_in = mctu_pkg::ST_SEG_M1;
         mctu_pkg::ST_SEG_M1: state_in = mctu_pkg::ST_EVAL;
         mctu_pkg::ST_EVAL: begin
            if (stat.flat || !stat.region) begin
               state_in = mctu_pkg::ST_SEG_WR;
            end else if (stat.a_pos) begin
               state_in = mctu_pkg::ST_MUL_AX;
            end else begin
               state_in = mctu_pkg::ST_MUL_M0SQ;
            end
         end
         mctu_pkg::ST_MUL_AX: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_MUL_YY;
         end
         mctu_pkg::ST_MUL_YY: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_CMP;
         end
         mctu_pkg::ST_CMP: begin
            state_in = stat.lt ? mctu_pkg::ST_MUL_M0SQ : mctu_pkg::ST_SEG_WR;
         end
         mctu_pkg::ST_MUL_M0SQ: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_MUL_M1SQ;
         end
         mctu_pkg::ST_MUL_M1SQ: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_SQRT;
         end
         mctu_pkg::ST_SQRT: begin
            if (stat.sqrt_done) state_in = mctu_pkg::ST_MUL_M0D;
         end
         mctu_pkg::ST_MUL_M0D: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_DIV_M0;
         end
         mctu_pkg::ST_DIV_M0: begin
            if (stat.div_done) state_in = mctu_pkg::ST_MUL_M1D;
         end
         mctu_pkg::ST_MUL_M1D: begin
            if (stat.mul_done) state_in = mctu_pkg::ST_DIV_M1;
         end
         mctu_pkg::ST_DIV_M1: begin
            if (stat.div_done) state_in = mctu_pkg::ST_SEG_WR;
         end
         mctu_pkg::ST_SEG_WR: begin
            state_in = stat.seg_more ? mctu_pkg::ST_SEG_RD : mctu_pkg::ST_LAST_WR;
         end
         mctu_pkg::ST_LAST_WR: begin
            state_in = stat.axis_last ? mctu_pkg::ST_OUT : mctu_pkg::ST_AX_RD0;
         end
         mctu_pkg::ST_OUT: begin
            if (stat.out_last) state_in = mctu_pkg::ST_IDLE;
         end
         default: state_in = mctu_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op       = mctu_pkg::OP_NONE;
      cmd.mul_run  = 1'b0;
      cmd.mul_sel  = mctu_pkg::MS_AX;
      cmd.div_run  = 1'b0;
      cmd.div_sel  = mctu_pkg::DS_M0;
      cmd.sqrt_run = 1'b0;
      busy         = (state_ff != mctu_pkg::ST_IDLE);
      case (state_ff)
         mctu_pkg::ST_IDLE: begin
            if (start) cmd.op = mctu_pkg::OP_LOAD;
         end
         mctu_pkg::ST_AX_RD0: cmd.op = mctu_pkg::OP_RD0;
         mctu_pkg::ST_AX_RD1: cmd.op = mctu_pkg::OP_RD1;
         mctu_pkg::ST_AX_RD2: cmd.op = mctu_pkg::OP_RD2;
         mctu_pkg::ST_SEG_RD: cmd.op = mctu_pkg::OP_SEGRD;
         mctu_pkg::ST_SEG_M1: cmd.op = mctu_pkg::OP_SEGM1;
         mctu_pkg::ST_EVAL:   cmd.op = mctu_pkg::OP_EVAL;
         mctu_pkg::ST_MUL_AX: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_AX;
         end
         mctu_pkg::ST_MUL_YY: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_YY;
         end
         mctu_pkg::ST_MUL_M0SQ: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_M0SQ;
         end
         mctu_pkg::ST_MUL_M1SQ: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_M1SQ;
         end
         mctu_pkg::ST_SQRT: cmd.sqrt_run = 1'b1;
         mctu_pkg::ST_MUL_M0D: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_M0D;
         end
         mctu_pkg::ST_DIV_M0: begin
            cmd.div_run = 1'b1;
            cmd.div_sel = mctu_pkg::DS_M0;
         end
         mctu_pkg::ST_MUL_M1D: begin
            cmd.mul_run = 1'b1;
            cmd.mul_sel = mctu_pkg::MS_M1D;
         end
         mctu_pkg::ST_DIV_M1: begin
            cmd.div_run = 1'b1;
            cmd.div_sel = mctu_pkg::DS_M1;
         end
         mctu_pkg::ST_SEG_WR:  cmd.op = mctu_pkg::OP_SEGWR;
         mctu_pkg::ST_LAST_WR: cmd.op = mctu_pkg::OP_LASTWR;
         mctu_pkg::ST_OUT:     cmd.op = mctu_pkg::OP_OUT;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mctu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/monotone_cubic_tangent_engine_unit.sv =====
// Loading accepts one point per cycle while idle; a point without the last mark gives no result.
// After the last point each axis runs its read states and, per segment, read, evaluate and
// write states, plus a product test and, for a rescale, four multiplies, a square root
// and two bit-serial divisions, which dominate. Results then stream one per cycle.
// Synchronous reset empties the point set.
`include "monotone_cubic_tangent_engine_unit_macros.svh"

module monotone_cubic_tangent_engine_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_0,
   input  logic [31:0] req_pos_1,
   input  logic [31:0] req_pos_2,
   input  logic [31:0] req_pos_3,
   input  logic [31:0] req_pos_4,
   input  logic [31:0] req_pos_5,
   input  logic        req_last_point,
   output logic        rsp_valid,
   output logic [31:0] rsp_slope_0,
   output logic [31:0] rsp_slope_1,
   output logic [31:0] rsp_slope_2,
   output logic [31:0] rsp_slope_3,
   output logic [31:0] rsp_slope_4,
   output logic [31:0] rsp_slope_5,
   output logic        rsp_last_slope,
   output logic        rsp_too_many_points
);

   mctu_pkg::dp_cmd_type  cmd;
   mctu_pkg::dp_stat_type stat;
   mctu_pkg::row_type     load_row, out_row;

   // Gather the coordinates of one transfer into a row.
   always_comb begin
      load_row[0] = req_pos_0;
      load_row[1] = req_pos_1;
      load_row[2] = req_pos_2;
      load_row[3] = req_pos_3;
      load_row[4] = req_pos_4;
      load_row[5] = req_pos_5;
   end

   mctu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_point (req_last_point),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   mctu_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_row  (load_row),
      .stat      (stat),
      .out_row   (out_row),
      .out_valid (rsp_valid),
      .out_last  (rsp_last_slope),
      .out_drop  (rsp_too_many_points)
   );

   assign rsp_slope_0 = out_row[0];
   assign rsp_slope_1 = out_row[1];
   assign rsp_slope_2 = out_row[2];
   assign rsp_slope_3 = out_row[3];
   assign rsp_slope_4 = out_row[4];
   assign rsp_slope_5 = out_row[5];

   // A result only follows a busy cycle.
   `MCTU_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "result without work")
   // A transfer with the last mark starts the computation.
   `MCTU_ASSERT_NEXT(a_last_starts, clock, reset, start && !busy && req_last_point, busy, "no compute")
   // A transfer without the last mark keeps the engine idle.
   `MCTU_ASSERT_NEXT(a_load_idle, clock, reset, start && !busy && !req_last_point, !busy, "went busy")
   // Nothing follows the final result of a set.
   `MCTU_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_last_slope, !rsp_valid, "extra result")

endmodule
